// ===== src/lru_page_replacement_top_assert.svh =====
// Assertion macros for the LRU page replacement block.
// Used by lru_page_replacement_top; needs no other file.
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define LRUPR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lru_page_replacement assertion failed");
`define LRUPR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lru_page_replacement assertion failed");
`else
`define LRUPR_ASSERT(lbl, clk, rstn, prop)
`define LRUPR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/lrupr_pkg.sv =====
// Shared widths and constants for the LRU page replacement block.
// Has no dependencies; used by lru_page_replacement_top.
package lrupr_pkg;

    localparam int CNT_W   = 3;
    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 2;
    localparam int FAULT_W = 32;

    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [FAULT_W-1:0] t_fault;
    typedef logic [CNT_W-1:0]   t_cnt;

endpackage

// ===== src/lru_page_replacement_top.sv =====
// LRU page replacement over a small set of frames, one sequenced scan unit.
// Depends on lrupr_pkg and lru_page_replacement_top_assert.svh.
//
// Usage:
// A page reference request arrives on i_valid/i_page and is taken when
// o_stall is low. One result request leaves on o_valid with hit, frame slot,
// evicted page and the saturating fault total; it is taken when i_stall is low.
// The frame count register is written through i_cfg_valid/i_cfg_data while
// o_cfg_ready is high; write it only while the block is idle.
// Operation: after an accepted request, one comparator and one rank compare
// step through the active frames, one frame per cycle, then the update state
// writes pages and ranks and the finish state loads the output register once
// it is free. A request scans its active frames (at most the frame count),
// and the next request is taken once the block has returned to idle.
// A stalled result stays in the output register while the next request is
// already being processed; that request then waits before delivery.
// Reset clears the frames in use, all ranks, the fault count and any pending
// result, and sets the frame count to 4. No clearing pass is needed.
module lru_page_replacement_top #(
    parameter int FRAMES = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lrupr_pkg::PAGE_W-1:0]        i_page,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [lrupr_pkg::SLOT_W-1:0]        o_frame_slot,
    output logic                                o_evicted_valid,
    output logic [lrupr_pkg::PAGE_W-1:0]        o_evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]       o_fault_total,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lrupr_pkg::CNT_W-1:0]         i_cfg_data
);

    localparam int SLOTS = (FRAMES < 7) ? FRAMES : 7;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);
    localparam lrupr_pkg::t_cnt SLOTS_C = lrupr_pkg::CNT_W'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FINISH
    } t_state;

    t_state                 r_state;
    lrupr_pkg::t_page       r_pages [0:SLOTS-1];
    logic [RW-1:0]          r_rank  [0:SLOTS-1];
    lrupr_pkg::t_cnt        r_filled;
    lrupr_pkg::t_fault      r_fault;
    lrupr_pkg::t_cnt        r_frame_count;

    lrupr_pkg::t_page       r_page;
    lrupr_pkg::t_cnt        r_active;
    logic                   r_can_fill;
    lrupr_pkg::t_cnt        r_idx;
    logic                   r_hit;
    lrupr_pkg::t_cnt        r_hit_slot;
    logic [RW-1:0]          r_hit_rank;
    logic [RW-1:0]          r_best;
    lrupr_pkg::t_cnt        r_best_slot;
    lrupr_pkg::t_page       r_best_page;

    logic                   r_res_hit;
    lrupr_pkg::t_cnt        r_res_slot;
    logic                   r_res_ev;
    lrupr_pkg::t_page       r_res_evp;

    logic                   r_o_valid;
    logic                   r_o_hit;
    logic [lrupr_pkg::SLOT_W-1:0] r_o_slot;
    logic                   r_o_ev;
    lrupr_pkg::t_page       r_o_evp;
    lrupr_pkg::t_fault      r_o_fault;

    lrupr_pkg::t_cnt        w_count;
    lrupr_pkg::t_cnt        w_active;
    lrupr_pkg::t_page       w_cur_page;
    logic [RW-1:0]          w_cur_rank;
    lrupr_pkg::t_cnt        w_slot;
    lrupr_pkg::t_cnt        w_age_active;
    logic                   w_age_all;
    logic                   w_write;
    logic                   w_in_acc;
    logic                   w_out_free;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_free  = !r_o_valid || !i_stall;

    always_comb begin
        if (r_frame_count == '0) begin
            w_count = lrupr_pkg::CNT_W'(1);
        end else if (r_frame_count > SLOTS_C) begin
            w_count = SLOTS_C;
        end else begin
            w_count = r_frame_count;
        end
        w_active   = (r_filled < w_count) ? r_filled : w_count;
        w_cur_page = r_pages[r_idx[SW-1:0]];
        w_cur_rank = r_rank[r_idx[SW-1:0]];
    end

    always_comb begin
        if (r_hit) begin
            w_slot       = r_hit_slot;
            w_age_active = r_active;
            w_age_all    = 1'b0;
            w_write      = 1'b0;
        end else if (r_can_fill) begin
            w_slot       = r_filled;
            w_age_active = r_filled + lrupr_pkg::CNT_W'(1);
            w_age_all    = 1'b1;
            w_write      = 1'b1;
        end else begin
            w_slot       = r_best_slot;
            w_age_active = r_active;
            w_age_all    = 1'b1;
            w_write      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE && w_write) begin
            r_pages[w_slot[SW-1:0]] <= r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_filled      <= '0;
            r_fault       <= '0;
            r_frame_count <= lrupr_pkg::CNT_W'(4);
            r_o_valid     <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_frame_count <= i_cfg_data;
            end
            if (r_o_valid && !i_stall && r_state != S_FINISH) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_page     <= i_page;
                        r_active   <= w_active;
                        r_can_fill <= (r_filled < w_count);
                        r_idx      <= '0;
                        r_hit      <= 1'b0;
                        r_hit_slot <= '0;
                        r_hit_rank <= '0;
                        r_best     <= '0;
                        r_best_slot <= '0;
                        r_best_page <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == r_active) begin
                        r_state <= S_UPDATE;
                    end else begin
                        if (!r_hit && w_cur_page == r_page) begin
                            r_hit      <= 1'b1;
                            r_hit_slot <= r_idx;
                            r_hit_rank <= w_cur_rank;
                        end
                        if (r_idx == '0 || w_cur_rank > r_best) begin
                            r_best      <= w_cur_rank;
                            r_best_slot <= r_idx;
                            r_best_page <= w_cur_page;
                        end
                        r_idx <= r_idx + lrupr_pkg::CNT_W'(1);
                    end
                end
                S_UPDATE: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (lrupr_pkg::CNT_W'(i) == w_slot) begin
                            r_rank[i] <= '0;
                        end else if (lrupr_pkg::CNT_W'(i) < w_age_active &&
                                     (w_age_all || r_rank[i] < r_hit_rank) &&
                                     r_rank[i] < RANK_MAX) begin
                            r_rank[i] <= r_rank[i] + RW'(1);
                        end
                    end
                    if (!r_hit) begin
                        if (r_fault != lrupr_pkg::FAULT_MAX) begin
                            r_fault <= r_fault + lrupr_pkg::FAULT_W'(1);
                        end
                        if (r_can_fill) begin
                            r_filled <= r_filled + lrupr_pkg::CNT_W'(1);
                        end
                    end
                    r_res_hit  <= r_hit;
                    r_res_slot <= w_slot;
                    r_res_ev   <= !r_hit && !r_can_fill;
                    r_res_evp  <= (!r_hit && !r_can_fill) ? r_best_page : '0;
                    r_state    <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_hit   <= r_res_hit;
                        r_o_slot  <= r_res_slot[lrupr_pkg::SLOT_W-1:0];
                        r_o_ev    <= r_res_ev;
                        r_o_evp   <= r_res_evp;
                        r_o_fault <= r_fault;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_hit           = r_o_hit;
    assign o_frame_slot    = r_o_slot;
    assign o_evicted_valid = r_o_ev;
    assign o_evicted_page  = r_o_evp;
    assign o_fault_total   = r_o_fault;

`include "lru_page_replacement_top_assert.svh"

    `LRUPR_ASSERT(a_filled_bound, i_clk, i_rst_n, r_filled <= SLOTS_C)
    `LRUPR_ASSERT(a_hit_no_evict, i_clk, i_rst_n, o_valid |-> !(o_hit && o_evicted_valid))
    `LRUPR_ASSERT(a_evp_zero, i_clk, i_rst_n, (o_valid && !o_evicted_valid) |-> (o_evicted_page == '0))
    `LRUPR_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_idx <= r_active))

endmodule
